/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/mjtg_pkg.sv */
package mjtg_pkg;

    typedef enum logic [1:0] {
        CFG_START_POSITION = 2'd0,
        CFG_GOAL_POSITION  = 2'd1,
        CFG_STEP_COUNT     = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    localparam int BLEND_Q_COEF = 15;
    localparam int BLEND_T_COEF = 10;
    localparam int BLEND_S_COEF = 6;
    localparam int STEP_COUNT_RESET = 1000;

endpackage

/* hdl/mjtg_div.sv */
`include "assert_macros.svh"

module mjtg_div
    import mjtg_pkg::*;
#(
    parameter int SB = 16,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SB-1:0] i_dividend,
    input  logic [SB-1:0] i_divisor,
    output t_unit_sts     o_sts,
    output logic [QW-1:0] o_quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [SB-1:0] r_rem;
    logic [SB-1:0] r_div;
    logic [QW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [SB:0] rem2;
    logic [SB:0] diff;
    logic        ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem2 = {r_rem, 1'b0};
        ge   = rem2 >= {1'b0, r_div};
        diff = rem2 - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[SB-1:0] : rem2[SB-1:0];
            r_quo <= {r_quo[QW-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

    `ASSERT_IMPLY(a_rem_below_divisor, i_clk, i_rst_n, r_busy, r_rem < r_div)
    `ASSERT_NEXT(a_div_done_single, i_clk, i_rst_n, r_done, !r_done && !r_busy)

endmodule

/* hdl/mjtg_mul.sv */
`include "assert_macros.svh"

module mjtg_mul
    import mjtg_pkg::*;
#(
    parameter int AW    = 32,
    parameter int BW    = 17,
    parameter int SHIFT = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [AW-1:0]          i_a,
    input  logic [BW-1:0]          i_b,
    output t_unit_sts              o_sts,
    output logic [AW+BW-SHIFT-1:0] o_product
);

    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [AW-1:0] r_acc;
    logic [BW-1:0] r_low;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [AW:0] sum;

    // lsb-first shift-add, one multiplier bit per cycle
    assign sum = {1'b0, r_acc} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_low <= '0;
        end else if (r_busy) begin
            r_acc <= sum[AW:1];
            r_low <= {sum[0], r_low[BW-1:1]};
            r_b   <= {1'b0, r_b[BW-1:1]};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_product  = {r_acc, r_low[BW-1:SHIFT]};

    `ASSERT_NEXT(a_mul_done_single, i_clk, i_rst_n, r_done, !r_done && !r_busy)

endmodule

/* hdl/minimum_jerk_trajectory_generator_unit.sv */
// one axis of a minimum-jerk point-to-point profile, one sample per transaction
// config: write start, goal and step count through the write port while idle
// input channel: i_in_valid / o_in_ready, payload i_restart (1 restarts at sample 0)
// output channel: o_out_valid / i_out_ready, payload position, sample index, last
// each input transaction yields exactly one output transaction
// an accepted sample runs through the bit-serial divider followed by five passes
//   of the bit-serial multiplier, then the finish state loads the output register
// samples at or past the end skip the arithmetic and go straight from accept to
//   the finish state
// one sample is in work at a time; o_in_ready is high only between samples
// the result sits in an output register, so a new sample is accepted while it
// waits; a stalled receiver holds the result and stops the next one at the end
// of its arithmetic until the register frees up
// reset: counter to zero, start and goal to zero, step count to 1000, no output
`include "assert_macros.svh"

module minimum_jerk_trajectory_generator_unit
    import mjtg_pkg::*;
#(
    parameter int POSITION_BITS       = 32,
    parameter int PHASE_FRACTION_BITS = 16,
    parameter int STEP_BITS           = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [((POSITION_BITS > STEP_BITS) ? POSITION_BITS : STEP_BITS)-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_restart,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [POSITION_BITS-1:0]   o_position,
    output logic [STEP_BITS-1:0]       o_sample_index,
    output logic                       o_last
);

    localparam int P  = POSITION_BITS;
    localparam int F  = PHASE_FRACTION_BITS;
    localparam int SB = STEP_BITS;
    localparam int TW = F + 4;
    localparam int MW = (P > TW) ? P : TW;
    localparam logic [TW-1:0] Q_BASE = TW'(BLEND_Q_COEF * (2 ** F));
    localparam logic [TW-1:0] T_BASE = TW'(BLEND_T_COEF * (2 ** F));

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_Q,
        S_MUL_T,
        S_MUL_OFF,
        S_FINISH
    } t_state;

    t_state         r_state, n_state;
    logic [P-1:0]   r_start, r_goal;
    logic [SB-1:0]  r_steps;
    logic [SB-1:0]  r_counter, n_counter;
    logic [SB-1:0]  r_index, n_index;
    logic           r_last, n_last;
    logic [F-1:0]   r_s, n_s;
    logic [1:0]     r_pass, n_pass;
    logic           r_neg, n_neg;
    logic [P-1:0]   r_result, n_result;
    logic           r_div_start, n_div_start;
    logic           r_mul_start, n_mul_start;
    logic [MW-1:0]  r_mul_a, n_mul_a;
    logic [F:0]     r_mul_b, n_mul_b;
    logic           r_out_valid, n_out_valid;
    logic [P-1:0]   r_position, n_position;
    logic [SB-1:0]  r_sample_index, n_sample_index;
    logic           r_out_last, n_out_last;

    t_unit_sts      div_sts, mul_sts;
    logic [F-1:0]   div_quo;
    logic [MW:0]    mul_prod;

    logic [SB-1:0]  idx_sel, idx_clamp;
    logic [TW-1:0]  q_val, six_s, t_val;
    logic [P:0]     diff, mag_w;
    logic [P-1:0]   off;

    mjtg_div #(.SB(SB), .QW(F)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_index),
        .i_divisor  (r_steps),
        .o_sts      (div_sts),
        .o_quotient (div_quo)
    );

    mjtg_mul #(.AW(MW), .BW(F + 1), .SHIFT(F)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_a       (r_mul_a),
        .i_b       (r_mul_b),
        .o_sts     (mul_sts),
        .o_product (mul_prod)
    );

    always_comb begin
        idx_sel   = i_restart ? '0 : r_counter;
        idx_clamp = (idx_sel > r_steps) ? r_steps : idx_sel;
        six_s     = (TW'(div_quo) << 2) + (TW'(div_quo) << 1);
        q_val     = Q_BASE - six_s;
        t_val     = T_BASE - mul_prod[TW-1:0];
        diff      = {r_goal[P-1], r_goal} - {r_start[P-1], r_start};
        mag_w     = diff[P] ? (~diff + 1'b1) : diff;
        off       = mul_prod[P-1:0];
    end

    always_comb begin
        n_state        = r_state;
        n_counter      = r_counter;
        n_index        = r_index;
        n_last         = r_last;
        n_s            = r_s;
        n_pass         = r_pass;
        n_neg          = r_neg;
        n_result       = r_result;
        n_div_start    = 1'b0;
        n_mul_start    = 1'b0;
        n_mul_a        = r_mul_a;
        n_mul_b        = r_mul_b;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_position     = r_position;
        n_sample_index = r_sample_index;
        n_out_last     = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_index   = idx_clamp;
                    n_last    = idx_clamp == r_steps;
                    n_counter = (idx_clamp < r_steps) ? idx_clamp + SB'(1) : r_steps;
                    if (idx_clamp == r_steps) begin
                        n_result = r_goal;
                        n_state  = S_FINISH;
                    end else begin
                        n_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    n_s         = div_quo;
                    n_mul_a     = MW'(q_val);
                    n_mul_b     = (F + 1)'(div_quo);
                    n_mul_start = 1'b1;
                    n_state     = S_MUL_Q;
                end
            end
            S_MUL_Q: begin
                if (mul_sts.done) begin
                    n_mul_a     = MW'(t_val);
                    n_mul_b     = (F + 1)'(r_s);
                    n_mul_start = 1'b1;
                    n_pass      = 2'd0;
                    n_state     = S_MUL_T;
                end
            end
            S_MUL_T: begin
                if (mul_sts.done) begin
                    n_mul_start = 1'b1;
                    if (r_pass == 2'd2) begin
                        n_neg   = diff[P];
                        n_mul_a = MW'(mag_w[P-1:0]);
                        n_mul_b = mul_prod[F:0];
                        n_state = S_MUL_OFF;
                    end else begin
                        n_pass  = r_pass + 2'd1;
                        n_mul_a = MW'(mul_prod[TW-1:0]);
                        n_mul_b = (F + 1)'(r_s);
                    end
                end
            end
            S_MUL_OFF: begin
                if (mul_sts.done) begin
                    n_result = r_neg ? (r_start - off) : (r_start + off);
                    n_state  = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_position     = r_result;
                    n_sample_index = r_index;
                    n_out_last     = r_last;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= '0;
            r_goal      <= '0;
            r_steps     <= SB'(STEP_COUNT_RESET);
            r_counter   <= '0;
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_counter   <= n_counter;
            r_div_start <= n_div_start;
            r_mul_start <= n_mul_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_START_POSITION) begin
                    r_start <= i_cfg_data[P-1:0];
                end else if (i_cfg_index == CFG_GOAL_POSITION) begin
                    r_goal <= i_cfg_data[P-1:0];
                end else if (i_cfg_index == CFG_STEP_COUNT) begin
                    r_steps <= i_cfg_data[SB-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_index        <= n_index;
        r_last         <= n_last;
        r_s            <= n_s;
        r_pass         <= n_pass;
        r_neg          <= n_neg;
        r_result       <= n_result;
        r_mul_a        <= n_mul_a;
        r_mul_b        <= n_mul_b;
        r_position     <= n_position;
        r_sample_index <= n_sample_index;
        r_out_last     <= n_out_last;
    end

    assign o_in_ready     = r_state == S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_position     = r_position;
    assign o_sample_index = r_sample_index;
    assign o_last         = r_out_last;

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_IMPLY(a_units_quiet_when_idle, i_clk, i_rst_n, o_in_ready, !div_sts.busy && !mul_sts.busy)
    `ASSERT_IMPLY(a_last_matches_steps, i_clk, i_rst_n, o_out_valid, o_last == (o_sample_index == r_steps))
    `ASSERT_IMPLY(a_last_holds_goal, i_clk, i_rst_n, o_out_valid && o_last, o_position == r_goal)

endmodule
